// ----- rtl/dpmd_pkg.sv -----
package dpmd_pkg;

   localparam int ERR_W   = 16;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int GAIN_W  = 10;
   localparam int LEVEL_W = 14;
   localparam int CMD_W   = 15;
   localparam int DUTY_W  = 14;

   // product and sum widths: unsigned gains carry an extra sign bit
   localparam int P_W    = GAIN_W + 1 + ERR_W;
   localparam int D_W    = GAIN_W + 1 + DIFF_W;
   localparam int TERM_W = D_W + 1;
   localparam int SUM_W  = TERM_W + 1;

   localparam int COMMAND_LIMIT = 10000;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   localparam logic [CSR_IDX_W-1:0] REG_PROPORTIONAL_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DERIVATIVE_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_DRIVE        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FORWARD_LIMIT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE_LIMIT     = 3'd4;

   localparam logic [LEVEL_W-1:0] LIMIT_RESET = 14'd10000;

   typedef struct packed {
      logic [GAIN_W-1:0]  proportional_gain;
      logic [GAIN_W-1:0]  derivative_gain;
      logic [LEVEL_W-1:0] base_drive;
      logic [LEVEL_W-1:0] forward_limit;
      logic [LEVEL_W-1:0] reverse_limit;
   } cfg_type;

   typedef struct packed {
      logic [DUTY_W-1:0] fwd;
      logic [DUTY_W-1:0] rev;
   } duty_type;

endpackage

// ----- rtl/differential_pd_motor_drive_core.sv -----
// PD steering controller for a two-wheel differential drive.
// Request channel (req_valid/req_ready, req_steer_error): one signed steering
// error per control period. Response channel (rsp_valid/rsp_ready): both
// saturated wheel commands and the forward/reverse PWM duties of each wheel.
// Configuration (csr_write_en/csr_index/csr_wdata): gains, base drive and the
// duty limits; change them only while no request is in flight.
// Pipeline: input register (error and error difference), PD term register
// (the two gain multiplies), response register (base add, saturation, duty
// split), in that order. One request is taken every cycle until a receiver
// stall fills all three; the multiply stage sets the cycle time.
// The previous error updates when a request is taken.
// Reset clears the pipeline, the previous error, the gains and the base
// drive, and sets both duty limits to 10000.
// When the receiver stalls, the pipeline fills behind the response register
// and req_ready drops once all three stages hold a request.
module differential_pd_motor_drive_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [dpmd_pkg::ERR_W-1:0]      req_steer_error,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [dpmd_pkg::CMD_W-1:0]      rsp_left_command,
   output logic signed [dpmd_pkg::CMD_W-1:0]      rsp_right_command,
   output logic [dpmd_pkg::DUTY_W-1:0]            rsp_left_forward_duty,
   output logic [dpmd_pkg::DUTY_W-1:0]            rsp_left_reverse_duty,
   output logic [dpmd_pkg::DUTY_W-1:0]            rsp_right_forward_duty,
   output logic [dpmd_pkg::DUTY_W-1:0]            rsp_right_reverse_duty,
   input  logic                                   csr_write_en,
   input  logic [dpmd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dpmd_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import dpmd_pkg::*;

   cfg_type                   cfg;
   logic                      term_valid, term_ready;
   logic signed [TERM_W-1:0]  term;

   dpmd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   dpmd_pd_term u_pd_term (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_steer_error (req_steer_error),
      .term_valid      (term_valid),
      .term_ready      (term_ready),
      .term            (term)
   );

   dpmd_drive_out u_drive_out (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg),
      .term_valid             (term_valid),
      .term_ready             (term_ready),
      .term                   (term),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_left_command       (rsp_left_command),
      .rsp_right_command      (rsp_right_command),
      .rsp_left_forward_duty  (rsp_left_forward_duty),
      .rsp_left_reverse_duty  (rsp_left_reverse_duty),
      .rsp_right_forward_duty (rsp_right_forward_duty),
      .rsp_right_reverse_duty (rsp_right_reverse_duty)
   );

endmodule

// ----- rtl/dpmd_csr.sv -----
module dpmd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [dpmd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dpmd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output dpmd_pkg::cfg_type                  cfg
);
   import dpmd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_PROPORTIONAL_GAIN: cfg_in.proportional_gain = csr_wdata[GAIN_W-1:0];
            REG_DERIVATIVE_GAIN:   cfg_in.derivative_gain   = csr_wdata[GAIN_W-1:0];
            REG_BASE_DRIVE:        cfg_in.base_drive        = csr_wdata[LEVEL_W-1:0];
            REG_FORWARD_LIMIT:     cfg_in.forward_limit     = csr_wdata[LEVEL_W-1:0];
            REG_REVERSE_LIMIT:     cfg_in.reverse_limit     = csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.proportional_gain <= '0;
         cfg_ff.derivative_gain   <= '0;
         cfg_ff.base_drive        <= '0;
         cfg_ff.forward_limit     <= LIMIT_RESET;
         cfg_ff.reverse_limit     <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/dpmd_pd_term.sv -----
module dpmd_pd_term (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dpmd_pkg::cfg_type                      cfg,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [dpmd_pkg::ERR_W-1:0]      req_steer_error,
   output logic                                   term_valid,
   input  logic                                   term_ready,
   output logic signed [dpmd_pkg::TERM_W-1:0]     term
);
   import dpmd_pkg::*;

   logic                      s1_valid_ff, s1_valid_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic                      term_valid_ff, term_valid_in;
   logic signed [TERM_W-1:0]  term_ff, term_in;

   logic                      s1_ready, s2_ready, take;
   logic signed [GAIN_W:0]    kp_s, kd_s;
   logic signed [P_W-1:0]     p_prod;
   logic signed [D_W-1:0]     d_prod;

   assign s2_ready  = !term_valid_ff || term_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign take      = req_valid && s1_ready;

   assign kp_s   = $signed({1'b0, cfg.proportional_gain});
   assign kd_s   = $signed({1'b0, cfg.derivative_gain});
   assign p_prod = P_W'(kp_s) * P_W'(err_ff);
   assign d_prod = D_W'(kd_s) * D_W'(diff_ff);

   always_comb begin
      s1_valid_in   = s1_ready ? req_valid : s1_valid_ff;
      err_in        = take ? req_steer_error : err_ff;
      diff_in       = take ? (DIFF_W'(req_steer_error) - DIFF_W'(prev_err_ff)) : diff_ff;
      // the error is remembered as soon as the request is taken
      prev_err_in   = take ? req_steer_error : prev_err_ff;
      term_valid_in = s2_ready ? s1_valid_ff : term_valid_ff;
      term_in       = (s1_valid_ff && s2_ready) ? (TERM_W'(p_prod) + TERM_W'(d_prod))
                                                : term_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         term_valid_ff <= 1'b0;
         prev_err_ff   <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         term_valid_ff <= term_valid_in;
         prev_err_ff   <= prev_err_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff  <= err_in;
      diff_ff <= diff_in;
      term_ff <= term_in;
   end

   assign term_valid = term_valid_ff;
   assign term       = term_ff;

endmodule

// ----- rtl/dpmd_drive_out.sv -----
module dpmd_drive_out (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dpmd_pkg::cfg_type                      cfg,
   input  logic                                   term_valid,
   output logic                                   term_ready,
   input  logic signed [dpmd_pkg::TERM_W-1:0]     term,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [dpmd_pkg::CMD_W-1:0]      rsp_left_command,
   output logic signed [dpmd_pkg::CMD_W-1:0]      rsp_right_command,
   output logic [dpmd_pkg::DUTY_W-1:0]            rsp_left_forward_duty,
   output logic [dpmd_pkg::DUTY_W-1:0]            rsp_left_reverse_duty,
   output logic [dpmd_pkg::DUTY_W-1:0]            rsp_right_forward_duty,
   output logic [dpmd_pkg::DUTY_W-1:0]            rsp_right_reverse_duty
);
   import dpmd_pkg::*;

   localparam logic signed [SUM_W-1:0] CMD_MAX = SUM_W'(COMMAND_LIMIT);
   localparam logic signed [SUM_W-1:0] CMD_MIN = -CMD_MAX;

   function automatic logic signed [SUM_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = v;
      if (v > CMD_MAX) r = CMD_MAX;
      if (v < CMD_MIN) r = CMD_MIN;
      return r;
   endfunction

   // zero command takes the forward side, so both duties come out zero
   function automatic duty_type split(input logic signed [SUM_W-1:0] cmd,
                                      input logic [LEVEL_W-1:0] fwd_lim,
                                      input logic [LEVEL_W-1:0] rev_lim);
      logic signed [SUM_W-1:0] mag;
      logic signed [SUM_W-1:0] lim;
      duty_type r;
      r = '0;
      if (cmd < 0) begin
         mag = -cmd;
         lim = $signed({{(SUM_W-LEVEL_W){1'b0}}, rev_lim});
         if (mag > lim) mag = lim;
         r.rev = mag[DUTY_W-1:0];
      end else begin
         mag = cmd;
         lim = $signed({{(SUM_W-LEVEL_W){1'b0}}, fwd_lim});
         if (mag > lim) mag = lim;
         r.fwd = mag[DUTY_W-1:0];
      end
      return r;
   endfunction

   logic                      valid_ff, valid_in;
   logic signed [CMD_W-1:0]   left_cmd_ff, left_cmd_in;
   logic signed [CMD_W-1:0]   right_cmd_ff, right_cmd_in;
   duty_type                  left_duty_ff, left_duty_in;
   duty_type                  right_duty_ff, right_duty_in;

   logic                      load;
   logic signed [SUM_W-1:0]   base_s, term_s, left_sat, right_sat;

   assign term_ready = !valid_ff || rsp_ready;
   assign load       = term_valid && term_ready;

   assign base_s    = $signed({{(SUM_W-LEVEL_W){1'b0}}, cfg.base_drive});
   assign term_s    = SUM_W'(term);
   assign left_sat  = saturate(base_s + term_s);
   assign right_sat = saturate(base_s - term_s);

   always_comb begin
      valid_in      = term_ready ? term_valid : valid_ff;
      left_cmd_in   = load ? left_sat[CMD_W-1:0] : left_cmd_ff;
      right_cmd_in  = load ? right_sat[CMD_W-1:0] : right_cmd_ff;
      left_duty_in  = load ? split(left_sat, cfg.forward_limit, cfg.reverse_limit)
                           : left_duty_ff;
      right_duty_in = load ? split(right_sat, cfg.forward_limit, cfg.reverse_limit)
                           : right_duty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_cmd_ff   <= left_cmd_in;
      right_cmd_ff  <= right_cmd_in;
      left_duty_ff  <= left_duty_in;
      right_duty_ff <= right_duty_in;
   end

   assign rsp_valid              = valid_ff;
   assign rsp_left_command       = left_cmd_ff;
   assign rsp_right_command      = right_cmd_ff;
   assign rsp_left_forward_duty  = left_duty_ff.fwd;
   assign rsp_left_reverse_duty  = left_duty_ff.rev;
   assign rsp_right_forward_duty = right_duty_ff.fwd;
   assign rsp_right_reverse_duty = right_duty_ff.rev;

endmodule

// ----- rtl/dpmd_checker.sv -----
module dpmd_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [dpmd_pkg::CMD_W-1:0]      rsp_left_command,
   input  logic signed [dpmd_pkg::CMD_W-1:0]      rsp_right_command,
   input  logic [dpmd_pkg::DUTY_W-1:0]            rsp_left_forward_duty,
   input  logic [dpmd_pkg::DUTY_W-1:0]            rsp_left_reverse_duty,
   input  logic [dpmd_pkg::DUTY_W-1:0]            rsp_right_forward_duty,
   input  logic [dpmd_pkg::DUTY_W-1:0]            rsp_right_reverse_duty
);
   import dpmd_pkg::*;

   // no response may come out of a pipeline that was just cleared
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an empty response register means every stage can move
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked while response register empty");

   // the idle side of each wheel carries zero duty
   a_duty_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_left_command[CMD_W-1] ? (rsp_left_forward_duty == '0)
                                    : (rsp_left_reverse_duty == '0)) &&
         (rsp_right_command[CMD_W-1] ? (rsp_right_forward_duty == '0)
                                     : (rsp_right_reverse_duty == '0)))
      else $error("duty on inactive channel");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_command) &&
         $stable(rsp_right_command))
      else $error("stalled response changed");

endmodule

bind differential_pd_motor_drive_core dpmd_checker u_dpmd_checker (.*);
